// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
package tcw_pkg;

  // Fixed field widths of the console ports
  localparam int ATTR_W    = 8;
  localparam int CHAR_W    = 8;
  localparam int CELL_W    = 16;
  localparam int RD_ROW_W  = 5;
  localparam int RD_COL_W  = 7;
  localparam int CUR_LIN_W = 11;
  localparam int CUR_ROW_W = 5;
  localparam int CUR_COL_W = 7;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  // Control bytes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0b;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0c;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // latch the incoming item
    logic scroll_init;  // start a scroll: clear sweep, pin cursor row
    logic copy;         // one step of the row copy
    logic fill;         // one blank write of the fill sweep
    logic exec;         // apply the byte or issue the cell read
    logic rdata;        // capture read data
    logic load;         // load the result register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scroll;
    logic copy_last;
    logic fill_last;
    logic is_read;
    logic is_ff;
  } dp_sts_t;

endpackage

// ----- hdl/tcw_ram.sv -----
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/tcw_ctrl.sv -----
`timescale 1ns / 1ps
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_pkg::dp_cmd_t  cmd,
  input  tcw_pkg::dp_sts_t  sts
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COPY  = 6'b000010,
    S_FILL  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_RDATA = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   exec_after_fill_r, exec_after_fill_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd                 = '0;
    state_nxt           = state_r;
    exec_after_fill_nxt = exec_after_fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.need_scroll) begin
            cmd.scroll_init     = 1'b1;
            exec_after_fill_nxt = 1'b1;
            state_nxt           = S_COPY;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) begin
          state_nxt = exec_after_fill_r ? S_EXEC : S_DONE;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_read) begin
          state_nxt = S_RDATA;
        end else if (sts.is_ff) begin
          exec_after_fill_nxt = 1'b0;
          state_nxt           = S_FILL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDATA: begin
        cmd.rdata = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      exec_after_fill_r <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      exec_after_fill_r <= exec_after_fill_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

endmodule

// ----- hdl/tcw_dp.sv -----
`timescale 1ns / 1ps
module tcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcw_pkg::dp_cmd_t                  cmd,
  output tcw_pkg::dp_sts_t                  sts,
  input  logic                              cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]        cfg_text_attribute,
  input  logic                              in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tcw_pkg::RD_ROW_W-1:0]      in_read_row,
  input  logic [tcw_pkg::RD_COL_W-1:0]      in_read_col,
  output logic [tcw_pkg::CUR_LIN_W-1:0]     out_cursor_linear,
  output logic [tcw_pkg::CUR_ROW_W-1:0]     out_cursor_row,
  output logic [tcw_pkg::CUR_COL_W-1:0]     out_cursor_col,
  output logic [tcw_pkg::CELL_W-1:0]        out_cell_value
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = CELLS - COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int LIN_W  = $clog2(CELLS + 1);

  logic [ATTR_W-1:0]    attr_r;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ADDR_W-1:0]    sweep_r, sweep_nxt;
  logic [CELL_W-1:0]    cell_r, cell_nxt;
  logic                 op_r;
  logic [CHAR_W-1:0]    ch_r;
  logic [RD_ROW_W-1:0]  rr_r;
  logic [RD_COL_W-1:0]  rc_r;

  logic [CUR_LIN_W-1:0] lin_out_r;
  logic [CUR_ROW_W-1:0] row_out_r;
  logic [CUR_COL_W-1:0] col_out_r;
  logic [CELL_W-1:0]    cell_out_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CELL_W-1:0]    ram_wdata, ram_rdata;

  logic [ADDR_W-1:0]    cur_addr, next_row_addr, rd_addr;
  logic [LIN_W-1:0]     cur_lin;
  logic [CELL_W-1:0]    blank;
  logic                 rd_ok;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign blank         = {attr_r, CH_SPACE};
  assign cur_addr      = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign next_row_addr = (ADDR_W'(row_r) + ADDR_W'(1)) * ADDR_W'(COLUMNS);
  assign rd_addr       = ADDR_W'(rr_r) * ADDR_W'(COLUMNS) + ADDR_W'(rc_r);
  assign rd_ok         = (32'(rr_r) < ROWS) && (32'(rc_r) < COLUMNS);
  assign cur_lin       = LIN_W'(row_r) * LIN_W'(COLUMNS) + LIN_W'(col_r);

  assign sts.need_scroll = (in_operation == OP_PUT) && (row_r > ROW_W'(ROWS - 2));
  assign sts.copy_last   = (sweep_r == ADDR_W'(COPY_N));
  assign sts.fill_last   = (sweep_r == ADDR_W'(CELLS - 1));
  assign sts.is_read     = (op_r == OP_READ);
  assign sts.is_ff       = (op_r == OP_PUT) && (ch_r == CH_FF);

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    sweep_nxt = sweep_r;
    cell_nxt  = cell_r;
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = blank;
    ram_raddr = rd_addr;

    if (cmd.scroll_init) begin
      sweep_nxt = '0;
      row_nxt   = ROW_W'(ROWS - 2);
    end

    // Copy writes the cell read in the cycle before: read row below, write the previous cell
    if (cmd.copy) begin
      ram_raddr = sweep_r + ADDR_W'(COLUMNS);
      ram_we    = (sweep_r != '0);
      ram_waddr = sweep_r - ADDR_W'(1);
      ram_wdata = ram_rdata;
      if (!sts.copy_last) begin
        sweep_nxt = sweep_r + ADDR_W'(1);
      end
    end

    if (cmd.fill) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = blank;
      sweep_nxt = sweep_r + ADDR_W'(1);
    end

    if (cmd.exec && (op_r == OP_PUT)) begin
      cell_nxt = '0;
      unique case (ch_r)
        CH_SPACE: begin
          if (col_r >= COL_W'(COLUMNS - 1)) begin
            row_nxt = row_r + ROW_W'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
        CH_BS: begin
          if (col_r != '0) begin
            col_nxt = col_r - COL_W'(1);
          end
        end
        CH_TAB: begin
          if (col_r > COL_W'(COLUMNS - 8)) begin
            row_nxt = row_r + ROW_W'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_r + COL_W'(8);
          end
        end
        CH_LF: begin
          row_nxt = row_r + ROW_W'(1);
          col_nxt = '0;
        end
        CH_CR: begin
          col_nxt = '0;
        end
        CH_FF: begin
          row_nxt   = '0;
          col_nxt   = '0;
          sweep_nxt = '0;
        end
        CH_VT: begin
        end
        default: begin
          ram_we    = 1'b1;
          ram_wdata = {attr_r, ch_r};
          if (col_r < COL_W'(COLUMNS - 1)) begin
            ram_waddr = cur_addr;
            col_nxt   = col_r + COL_W'(1);
          end else begin
            ram_waddr = next_row_addr;
            row_nxt   = row_r + ROW_W'(1);
            col_nxt   = COL_W'(1);
          end
        end
      endcase
    end

    if (cmd.rdata) begin
      cell_nxt = rd_ok ? ram_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r  <= ATTR_RESET;
      row_r   <= '0;
      col_r   <= '0;
      sweep_r <= '0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_text_attribute;
      end
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (cmd.accept) begin
      op_r <= in_operation;
      ch_r <= in_char_code;
      rr_r <= in_read_row;
      rc_r <= in_read_col;
    end
    if (cmd.load) begin
      lin_out_r  <= CUR_LIN_W'(cur_lin);
      row_out_r  <= CUR_ROW_W'(row_r);
      col_out_r  <= CUR_COL_W'(col_r);
      cell_out_r <= cell_r;
    end
  end

  assign out_cursor_linear = lin_out_r;
  assign out_cursor_row    = row_out_r;
  assign out_cursor_col    = col_out_r;
  assign out_cell_value    = cell_out_r;

endmodule

// ----- hdl/text_console_char_writer.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Transfer
// in_*      input      in_valid / in_stall    operation, char_code, read_row, read_col
// out_*     output     out_valid / out_stall  cursor_linear, cursor_row, cursor_col, cell_value
// cfg_*     input      cfg_we                 text_attribute (no read-back)
//
// A put passes through accept, execute and result load; a read adds the registered
// read of the screen RAM before the load. A new transfer is taken only in the idle state.
// A put with the cursor on the bottom row first scrolls: a row copy, then a blank fill
// of the bottom row.
// Form feed fills all COLUMNS*ROWS cells, one cell a cycle.
// Synchronous active-low reset clears cursor, attribute (0x0f) and control; the screen
// RAM is not cleared. A stalled result holds in the output register; the next item
// is taken meanwhile and waits in its final state until the register frees.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_text_attribute,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tcw_pkg::RD_ROW_W-1:0]   in_read_row,
  input  logic [tcw_pkg::RD_COL_W-1:0]   in_read_col,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcw_pkg::CUR_LIN_W-1:0]  out_cursor_linear,
  output logic [tcw_pkg::CUR_ROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::CUR_COL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::CELL_W-1:0]     out_cell_value
);
  import tcw_pkg::*;

  // Commands go one way, status comes back; nothing else crosses
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each transfer: accept, optional scroll copy and fill, apply the byte
  // or read the cell, fill the screen after a form feed, then load the output register.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold cursor, attribute, screen RAM and the result register.
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_text_attribute (cfg_text_attribute),
    .in_operation       (in_operation),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_cursor_linear  (out_cursor_linear),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_cell_value     (out_cell_value)
  );

endmodule
